/* hw/rtl/rsh_pkg.sv */
package rsh_pkg;

  localparam int unsigned NumBinsDef   = 64;
  localparam int unsigned BinWidthRst  = 1;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_BIN_WIDTH = 1'b0,
    REG_UNUSED    = 1'b1
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] sample;
    logic [5:0]  read_bin;
    logic        neg;
    logic        rb_ok;
  } item_t;

endpackage

/* hw/rtl/rsh_front.sv */
module rsh_front #(
  parameter int unsigned BIN_COUNT = rsh_pkg::NumBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic signed [31:0]  sample_i,
  input  logic [5:0]          read_bin_i,
  output logic                q_valid_o,
  output rsh_pkg::item_t      q_item_o,
  input  logic                q_pop_i
);
  import rsh_pkg::*;

  item_t       slot_q [QueueDepth];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item;
  logic        push;

  // classify the incoming word
  always_comb begin
    item.op       = op_e'(op_i);
    item.sample   = sample_i;
    item.read_bin = read_bin_i;
    item.neg      = sample_i[31];
    item.rb_ok    = (32'(read_bin_i) < 32'(BIN_COUNT));
  end

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = q_pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* hw/rtl/rsh_div.sv */
module rsh_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [30:0] quotient_o
);

  logic [15:0] rem_q, rem_d;
  logic [30:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic        qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[30]};
    qbit   = (trial >= {1'b0, divisor_i});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? 16'(trial - {1'b0, divisor_i}) : trial[15:0];
      quo_d = {quo_q[29:0], qbit};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd30) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

/* hw/rtl/rsh_back.sv */
module rsh_back #(
  parameter int unsigned BIN_COUNT = rsh_pkg::NumBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         divisor_i,
  input  logic                q_valid_i,
  input  rsh_pkg::item_t      q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         sample_count_o,
  output logic signed [63:0]  total_sum_o,
  output logic [63:0]         total_square_sum_o,
  output logic signed [31:0]  smallest_o,
  output logic signed [31:0]  largest_o,
  output logic                has_samples_o,
  output logic [5:0]          bin_number_o,
  output logic [31:0]         bin_total_o
);
  import rsh_pkg::*;

  localparam int unsigned IW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CLR  = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  item_t              cur_q, cur_d;
  logic [IW-1:0]      idx_q, idx_d, clr_q, clr_d;
  logic               clr_op_q, clr_op_d;
  logic [31:0]        count_q, count_d;
  logic signed [63:0] sum_q, sum_d;
  logic [63:0]        sqs_q, sqs_d, sq_q;
  logic signed [31:0] min_q, min_d, max_q, max_d;
  logic               ov_q, ov_d;
  logic [5:0]         bnum_q, bnum_d;
  logic [31:0]        btot_q, btot_d;
  logic [31:0]        mem [BIN_COUNT];
  logic [31:0]        ram_q, newb;
  logic               we, re;
  logic [IW-1:0]      waddr;
  logic [31:0]        wdata;
  logic               div_start, div_done;
  logic [30:0]        quo;
  logic [15:0]        width;
  logic signed [63:0] s64;
  logic signed [63:0] sq_w;
  logic signed [64:0] sum_x;
  logic [64:0]        sqs_x;
  logic [31:0]        idx_w;

  assign width = (divisor_i == 16'd0) ? 16'd1 : divisor_i;

  rsh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_d.sample[30:0]),
    .divisor_i  (width),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    s64    = 64'(signed'(cur_q.sample));
    sq_w   = signed'(cur_q.sample) * signed'(cur_q.sample);
    sum_x  = 65'(sum_q) + 65'(s64);
    sqs_x  = {1'b0, sqs_q} + {1'b0, sq_q};
    newb   = (ram_q == '1) ? ram_q : ram_q + 32'd1;
    idx_w  = 32'(idx_q);

    state_d   = state_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    clr_op_d  = clr_op_q;
    count_d   = count_q;
    sum_d     = sum_q;
    sqs_d     = sqs_q;
    min_d     = min_q;
    max_d     = max_q;
    ov_d      = ov_q && !out_ready_i;
    bnum_d    = bnum_q;
    btot_d    = btot_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_q;
    wdata     = newb;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          unique case (q_item_i.op)
            OP_ADD: begin
              if (q_item_i.neg) begin
                idx_d   = '0;
                state_d = S_RD;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_READ: begin
              if (q_item_i.rb_ok) begin
                idx_d   = IW'(q_item_i.read_bin);
                state_d = S_RD;
              end else begin
                bnum_d = q_item_i.read_bin;
                btot_d = '0;
                ov_d   = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              sum_d    = '0;
              sqs_d    = '0;
              min_d    = '0;
              max_d    = '0;
              clr_d    = '0;
              clr_op_d = 1'b1;
              state_d  = S_CLR;
            end
            OP_NONE: begin
              bnum_d = '0;
              btot_d = '0;
              ov_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(BIN_COUNT - 1)) begin
          state_d  = S_IDLE;
          clr_op_d = 1'b0;
          if (clr_op_q) begin
            bnum_d = '0;
            btot_d = '0;
            ov_d   = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_d   = ({1'b0, quo} >= 32'(BIN_COUNT)) ? IW'(BIN_COUNT - 1) : IW'(quo);
          state_d = S_RD;
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
        ov_d    = 1'b1;
        if (cur_q.op == OP_ADD) begin
          we      = 1'b1;
          bnum_d  = idx_w[5:0];
          btot_d  = newb;
          count_d = (count_q == '1) ? count_q : count_q + 32'd1;
          if (count_q == '0) begin
            min_d = signed'(cur_q.sample);
            max_d = signed'(cur_q.sample);
          end else begin
            if (signed'(cur_q.sample) < min_q) min_d = signed'(cur_q.sample);
            if (signed'(cur_q.sample) > max_q) max_d = signed'(cur_q.sample);
          end
          if (sum_x[64] != sum_x[63]) begin
            sum_d = sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            sum_d = sum_x[63:0];
          end
          sqs_d = sqs_x[64] ? '1 : sqs_x[63:0];
        end else begin
          bnum_d = cur_q.read_bin;
          btot_d = ram_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      ram_q <= mem[idx_q];
    end
    if (state_q == S_RD) begin
      sq_q <= sq_w;
    end
    cur_q <= cur_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      clr_op_q <= 1'b0;
      count_q  <= '0;
      sum_q    <= '0;
      sqs_q    <= '0;
      min_q    <= '0;
      max_q    <= '0;
      ov_q     <= 1'b0;
      bnum_q   <= '0;
      btot_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      clr_op_q <= clr_op_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      sqs_q    <= sqs_d;
      min_q    <= min_d;
      max_q    <= max_d;
      ov_q     <= ov_d;
      bnum_q   <= bnum_d;
      btot_q   <= btot_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign sample_count_o     = count_q;
  assign total_sum_o        = sum_q;
  assign total_square_sum_o = sqs_q;
  assign smallest_o         = min_q;
  assign largest_o          = max_q;
  assign has_samples_o      = (count_q != '0);
  assign bin_number_o       = bnum_q;
  assign bin_total_o        = btot_q;

endmodule

/* hw/rtl/running_stats_histogram.sv */
// channel   direction  handshake               payload
// in        input      in_valid_i/in_ready_o   op_i, sample_i, read_bin_i
// out       output     out_valid_o/out_ready_i sample_count_o .. bin_total_o
// cfg       apb        psel/penable/pready     bin width at address 0
//
// add of a non-negative sample: the bit-serial bin divider finds the bin, then one bin memory read and write
// add of a negative sample or bin read: one bin memory read, and for the add one write
// clear: one bin cleared per cycle; the same sweep runs after
// reset, during which no word leaves the front queue
// a two-word front queue keeps taking words, until it is full, while a result waits on out_ready_i
module running_stats_histogram #(
  parameter int unsigned BIN_COUNT = rsh_pkg::NumBinsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic signed [31:0]             sample_i,
  input  logic [5:0]                     read_bin_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    sample_count_o,
  output logic signed [63:0]             total_sum_o,
  output logic [63:0]                    total_square_sum_o,
  output logic signed [31:0]             smallest_o,
  output logic signed [31:0]             largest_o,
  output logic                           has_samples_o,
  output logic [5:0]                     bin_number_o,
  output logic [31:0]                    bin_total_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsh_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rsh_pkg::*;

  logic [15:0] bw_q;
  logic        q_valid, q_pop;
  item_t       q_item;
  reg_e        sel;

  assign sel    = reg_e'(paddr[2]);
  assign pready = 1'b1;
  assign prdata = (sel == REG_BIN_WIDTH) ? {16'd0, bw_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= 16'(BinWidthRst);
    end else if (psel && penable && pwrite && (sel == REG_BIN_WIDTH)) begin
      bw_q <= pwdata[15:0];
    end
  end

  rsh_front #(.BIN_COUNT(BIN_COUNT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .read_bin_i (read_bin_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  rsh_back #(.BIN_COUNT(BIN_COUNT)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .divisor_i          (bw_q),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sample_count_o     (sample_count_o),
    .total_sum_o        (total_sum_o),
    .total_square_sum_o (total_square_sum_o),
    .smallest_o         (smallest_o),
    .largest_o          (largest_o),
    .has_samples_o      (has_samples_o),
    .bin_number_o       (bin_number_o),
    .bin_total_o        (bin_total_o)
  );

endmodule
